FILE: rtl/mcwk_pkg.sv
// ----------------------------------------------------------------------------
// mcwk_pkg
// Shared types, mode codes and angle constants for the mecanum wheel
// kinematics block, plus the sine polynomial used to build the quarter table.
// ----------------------------------------------------------------------------
package mcwk_pkg;

  typedef logic [2:0]          mode_t;
  typedef logic signed [15:0]  speed_t;
  typedef logic signed [16:0]  offset_t;
  typedef logic signed [16:0]  sine_t;
  typedef logic signed [19:0]  wz_t;
  typedef logic signed [23:0]  gain_t;
  typedef logic signed [23:0]  ref_t;

  localparam mode_t MODE_ZERO_FORCE    = 3'd0;
  localparam mode_t MODE_NO_FOLLOW     = 3'd1;
  localparam mode_t MODE_FOLLOW_GIMBAL = 3'd2;
  localparam mode_t MODE_ROTATE        = 3'd3;
  localparam mode_t MODE_OTHER         = 3'd4;

  localparam logic [1:0] WHEEL_FL = 2'd0;
  localparam logic [1:0] WHEEL_FR = 2'd1;
  localparam logic [1:0] WHEEL_BL = 2'd2;
  localparam logic [1:0] WHEEL_BR = 2'd3;

  // Angles are in 1/256 degree; a quarter turn is 45 * 2^9.
  localparam int TURN         = 92160;
  localparam int QUARTER      = 23040;
  localparam int QUARTER_ODD  = 45;
  localparam int QUARTER_LOG2 = 9;

  localparam int ROTATE_SPIN  = 2500;
  localparam int REF_MAX      = 8388607;
  localparam int REF_MIN      = -8388608;

  // a times b (Q30), truncated toward zero
  function automatic longint mul_q30(input longint a, input longint b);
    longint mag;
    longint p;
    mag = (a < 0) ? -a : a;
    p   = (mag * b) >>> 30;
    return (a < 0) ? -p : p;
  endfunction

  // sin of x (Q30 fraction of a quarter turn), rounded to Q15, 0..32768
  function automatic logic [15:0] sine_poly(input longint x);
    longint x2;
    longint p;
    longint s;
    x2 = (x * x) >>> 30;
    p  = 64'sd172272;
    p  = -64'sd5026994   + mul_q30(p, x2);
    p  = 64'sd85569306   + mul_q30(p, x2);
    p  = -64'sd693598669 + mul_q30(p, x2);
    p  = 64'sd1686629713 + mul_q30(p, x2);
    s  = mul_q30(p, x);
    if (s < 0) s = 0;
    s = (s + 64'sd16384) >>> 15;
    if (s > 64'sd32768) s = 64'sd32768;
    return s[15:0];
  endfunction

endpackage

FILE: rtl/mcwk_if.sv
// ----------------------------------------------------------------------------
// mcwk_if
// Valid/ready channels for chassis commands and wheel reference words.
// ----------------------------------------------------------------------------
interface mcwk_in_if import mcwk_pkg::*; ();
  logic    valid;
  logic    ready;
  mode_t   mode;
  speed_t  forward_speed;
  speed_t  lateral_speed;
  speed_t  spin_command;
  offset_t gimbal_offset;
  logic    reverse_spin;

  modport source (output valid, output mode, output forward_speed, output lateral_speed,
                  output spin_command, output gimbal_offset, output reverse_spin,
                  input ready);
  modport sink (input valid, input mode, input forward_speed, input lateral_speed,
                input spin_command, input gimbal_offset, input reverse_spin,
                output ready);
endinterface

interface mcwk_out_if import mcwk_pkg::*; ();
  logic valid;
  logic ready;
  ref_t front_left_ref;
  ref_t front_right_ref;
  ref_t back_left_ref;
  ref_t back_right_ref;
  logic motors_enabled;

  modport source (output valid, output front_left_ref, output front_right_ref,
                  output back_left_ref, output back_right_ref, output motors_enabled,
                  input ready);
  modport sink (input valid, input front_left_ref, input front_right_ref,
                input back_left_ref, input back_right_ref, input motors_enabled,
                output ready);
endinterface

FILE: rtl/mecanum_chassis_wheel_kinematics.sv
// ----------------------------------------------------------------------------
// mecanum_chassis_wheel_kinematics
// Mecanum inverse kinematics: chassis command in, four wheel references out.
//
//   channel  direction  handshake          payload
//   in_ch    in         valid/ready        mode, speeds, spin, offset, reverse
//   out_ch   out        valid/ready        four 24-bit wheel refs, motor enable
//   cfg_*    in         APB-style write    four signed Q8.16 spin gains
//
// One word per cycle through nine register stages while out_ch is not
// stalled. The angle path (phase wrap, quadrant, index divide, table) takes
// five stages, the wheel mixer four. Each stage holds its own valid bit and
// loads when it is empty or the stage after it moves, so bubbles close up
// behind a stalled output word.
// Reset clears the valid bits and the spin gains; data registers are not reset.
// ----------------------------------------------------------------------------
module mecanum_chassis_wheel_kinematics import mcwk_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  mcwk_in_if.sink     in_ch,
  mcwk_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int NSTAGE = 9;
  localparam int NFRONT = 5;

  typedef struct packed {
    speed_t vx;
    speed_t vy;
    logic   motors;
  } side_t;

  logic [NSTAGE:1]  en;
  logic [NSTAGE:1]  v_r;
  side_t            side_nxt;
  side_t            side_r [NFRONT];
  gain_t [3:0]      gain_r;
  sine_t            sin_val;
  sine_t            cos_val;
  wz_t              wz;
  ref_t  [3:0]      wheel_ref;
  logic             motors_enabled;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_prdata = 32'(gain_r[cfg_paddr[3:2]]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      gain_r[cfg_paddr[3:2]] <= cfg_pwdata[23:0];
    end
  end

  // stage advance: load when empty or when the next stage moves
  always_comb begin
    en[NSTAGE] = !v_r[NSTAGE] || out_ch.ready;
    for (int s = NSTAGE - 1; s >= 1; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end

  assign in_ch.ready = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_ch.valid;
      for (int s = 2; s <= NSTAGE; s++) begin
        if (en[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  // carry speeds and the enable flag alongside the angle path
  always_comb begin
    side_nxt.vx     = in_ch.forward_speed;
    side_nxt.vy     = in_ch.lateral_speed;
    side_nxt.motors = (in_ch.mode != MODE_ZERO_FORCE);
  end

  always_ff @(posedge clk) begin
    if (en[1]) side_r[0] <= side_nxt;
    for (int s = 1; s < NFRONT; s++) begin
      if (en[s+1]) side_r[s] <= side_r[s-1];
    end
  end

  mcwk_angle #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_angle (
    .clk           (clk),
    .en            (en[NFRONT:1]),
    .gimbal_offset (in_ch.gimbal_offset),
    .sin_val       (sin_val),
    .cos_val       (cos_val)
  );

  mcwk_spin u_spin (
    .clk           (clk),
    .en            (en[NFRONT:1]),
    .mode          (in_ch.mode),
    .spin_command  (in_ch.spin_command),
    .gimbal_offset (in_ch.gimbal_offset),
    .reverse_spin  (in_ch.reverse_spin),
    .wz            (wz)
  );

  mcwk_wheel u_wheel (
    .clk            (clk),
    .en             (en[NSTAGE:NFRONT+1]),
    .vx             (side_r[NFRONT-1].vx),
    .vy             (side_r[NFRONT-1].vy),
    .sin_val        (sin_val),
    .cos_val        (cos_val),
    .wz             (wz),
    .motors         (side_r[NFRONT-1].motors),
    .gain           (gain_r),
    .wheel_ref      (wheel_ref),
    .motors_enabled (motors_enabled)
  );

  assign out_ch.valid           = v_r[NSTAGE];
  assign out_ch.front_left_ref  = wheel_ref[WHEEL_FL];
  assign out_ch.front_right_ref = wheel_ref[WHEEL_FR];
  assign out_ch.back_left_ref   = wheel_ref[WHEEL_BL];
  assign out_ch.back_right_ref  = wheel_ref[WHEEL_BR];
  assign out_ch.motors_enabled  = motors_enabled;

endmodule

FILE: rtl/mcwk_angle.sv
// ----------------------------------------------------------------------------
// mcwk_angle
// Five-stage sine/cosine of the gimbal offset: phase wrap, quadrant split,
// index scaling by reciprocal multiply, quarter-table lookup with mirroring.
// ----------------------------------------------------------------------------
module mcwk_angle import mcwk_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic       clk,
  input  logic [5:1] en,
  input  offset_t    gimbal_offset,
  output sine_t      sin_val,
  output sine_t      cos_val
);

  localparam int     NMAX = (QUARTER - 1) * SINE_TABLE_DEPTH + QUARTER / 2;
  localparam int     NW   = $clog2(NMAX + 1);
  localparam int     AW   = NW - QUARTER_LOG2;
  localparam int     SH   = AW + $clog2(QUARTER_ODD);
  localparam longint MUL  = ((longint'(1) << SH) + QUARTER_ODD - 1) / QUARTER_ODD;
  localparam int     MW   = $clog2(MUL + 1);
  localparam int     PW   = AW + MW;
  localparam int     KW   = $clog2(SINE_TABLE_DEPTH + 1);

  logic [15:0] rom [SINE_TABLE_DEPTH + 1];

  for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_rom
    localparam longint X = (longint'(i) << 30) / SINE_TABLE_DEPTH;
    assign rom[i] = sine_poly(X);
  end

  // lane 0 carries the sine, lane 1 the cosine
  logic [16:0]   phase_nxt [2];
  logic [16:0]   phase_r   [2];
  logic [1:0]    quad_nxt  [2];
  logic [14:0]   rem_nxt   [2];
  logic [1:0]    quad2_r   [2];
  logic [14:0]   rem2_r    [2];
  logic [NW-1:0] num_nxt   [2];
  logic [AW-1:0] a_nxt     [2];
  logic [1:0]    quad3_r   [2];
  logic [AW-1:0] a3_r      [2];
  logic [PW-1:0] prod_nxt  [2];
  logic [KW-1:0] k_nxt     [2];
  logic [1:0]    quad4_r   [2];
  logic [KW-1:0] k4_r      [2];
  logic [KW-1:0] idx       [2];
  logic [15:0]   mag       [2];
  sine_t         val_nxt   [2];
  sine_t         val_r     [2];

  logic signed [17:0] gx;
  logic [17:0]        ps;
  logic [17:0]        pc;

  always_comb begin
    gx = gimbal_offset;
    ps = gimbal_offset[16] ? 18'(gx + 18'sd92160) : 18'(gx);
    pc = ps + 18'(QUARTER);
    if (pc >= 18'(TURN)) pc = pc - 18'(TURN);
    phase_nxt[0] = ps[16:0];
    phase_nxt[1] = pc[16:0];
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    always_comb begin
      if (phase_r[l] >= 17'(3 * QUARTER)) begin
        quad_nxt[l] = 2'd3;
        rem_nxt[l]  = 15'(phase_r[l] - 17'(3 * QUARTER));
      end else if (phase_r[l] >= 17'(2 * QUARTER)) begin
        quad_nxt[l] = 2'd2;
        rem_nxt[l]  = 15'(phase_r[l] - 17'(2 * QUARTER));
      end else if (phase_r[l] >= 17'(QUARTER)) begin
        quad_nxt[l] = 2'd1;
        rem_nxt[l]  = 15'(phase_r[l] - 17'(QUARTER));
      end else begin
        quad_nxt[l] = 2'd0;
        rem_nxt[l]  = phase_r[l][14:0];
      end

      num_nxt[l]  = NW'(rem2_r[l]) * NW'(SINE_TABLE_DEPTH) + NW'(QUARTER / 2);
      a_nxt[l]    = num_nxt[l][NW-1:QUARTER_LOG2];

      // exact floor divide by the odd part of a quarter
      prod_nxt[l] = PW'(a3_r[l]) * PW'(MUL);
      k_nxt[l]    = prod_nxt[l][SH +: KW];

      // mirror in quadrants one and three, negate in the lower half turn
      idx[l]      = quad4_r[l][0] ? KW'(SINE_TABLE_DEPTH) - k4_r[l] : k4_r[l];
      mag[l]      = rom[idx[l]];
      val_nxt[l]  = quad4_r[l][1] ? -$signed({1'b0, mag[l]}) : $signed({1'b0, mag[l]});
    end

    always_ff @(posedge clk) begin
      if (en[1]) begin
        phase_r[l] <= phase_nxt[l];
      end
      if (en[2]) begin
        quad2_r[l] <= quad_nxt[l];
        rem2_r[l]  <= rem_nxt[l];
      end
      if (en[3]) begin
        quad3_r[l] <= quad2_r[l];
        a3_r[l]    <= a_nxt[l];
      end
      if (en[4]) begin
        quad4_r[l] <= quad3_r[l];
        k4_r[l]    <= k_nxt[l];
      end
      if (en[5]) begin
        val_r[l]   <= val_nxt[l];
      end
    end
  end

  assign sin_val = val_r[0];
  assign cos_val = val_r[1];

endmodule

FILE: rtl/mcwk_spin.sv
// ----------------------------------------------------------------------------
// mcwk_spin
// Spin rate selection by mode: squares the offset for follow-gimbal, applies
// the reverse flag, and delays the rate to line up with the angle pipeline.
// ----------------------------------------------------------------------------
module mcwk_spin import mcwk_pkg::*; (
  input  logic       clk,
  input  logic [5:1] en,
  input  mode_t      mode,
  input  speed_t     spin_command,
  input  offset_t    gimbal_offset,
  input  logic       reverse_spin,
  output wz_t        wz
);

  logic signed [17:0] gx;
  logic [16:0]        gabs_nxt;
  logic [16:0]        gabs1_r;
  logic               gneg1_r;
  mode_t              mode1_r;
  logic               rev1_r;
  speed_t             spin1_r;
  logic [33:0]        gsq2_r;
  logic               gneg2_r;
  mode_t              mode2_r;
  logic               rev2_r;
  speed_t             spin2_r;
  logic [34:0]        gsq_bias;
  logic [18:0]        follow_mag;
  wz_t                pick;
  wz_t                wz_nxt;
  wz_t                wz3_r;
  wz_t                wz4_r;
  wz_t                wz5_r;

  always_comb begin
    gx       = gimbal_offset;
    gabs_nxt = gimbal_offset[16] ? 17'(-gx) : 17'(gx);
  end

  always_comb begin
    gsq_bias   = 35'(gsq2_r) + 35'd8192;
    follow_mag = gsq_bias[32:14];
    case (mode2_r)
      MODE_NO_FOLLOW:     pick = '0;
      MODE_FOLLOW_GIMBAL: pick = gneg2_r ? wz_t'({1'b0, follow_mag})
                                         : -wz_t'({1'b0, follow_mag});
      MODE_ROTATE:        pick = wz_t'(ROTATE_SPIN);
      default:            pick = wz_t'(spin2_r);
    endcase
    wz_nxt = rev2_r ? -pick : pick;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      gabs1_r <= gabs_nxt;
      gneg1_r <= gimbal_offset[16];
      mode1_r <= mode;
      rev1_r  <= reverse_spin;
      spin1_r <= spin_command;
    end
    if (en[2]) begin
      gsq2_r  <= 34'(gabs1_r) * 34'(gabs1_r);
      gneg2_r <= gneg1_r;
      mode2_r <= mode1_r;
      rev2_r  <= rev1_r;
      spin2_r <= spin1_r;
    end
    if (en[3]) wz3_r <= wz_nxt;
    if (en[4]) wz4_r <= wz3_r;
    if (en[5]) wz5_r <= wz4_r;
  end

  assign wz = wz5_r;

endmodule

FILE: rtl/mcwk_wheel.sv
// ----------------------------------------------------------------------------
// mcwk_wheel
// Four-stage wheel mixer: frame rotation and spin products, rotated sums,
// per-wheel totals, then round and saturate into the output register.
// ----------------------------------------------------------------------------
module mcwk_wheel import mcwk_pkg::*; (
  input  logic        clk,
  input  logic [4:1]  en,
  input  speed_t      vx,
  input  speed_t      vy,
  input  sine_t       sin_val,
  input  sine_t       cos_val,
  input  wz_t         wz,
  input  logic        motors,
  input  gain_t [3:0] gain,
  output ref_t [3:0]  wheel_ref,
  output logic        motors_enabled
);

  logic signed [32:0] xc1_r, ys1_r, yc1_r, xs1_r;
  logic signed [43:0] wg1_r [4];
  logic               mot1_r;
  logic signed [33:0] sx2_r, sy2_r;
  logic signed [43:0] wg2_r [4];
  logic               mot2_r;
  logic signed [47:0] tot_nxt [4];
  logic signed [47:0] tot3_r [4];
  logic               mot3_r;
  logic signed [47:0] sx2w, sy2w;
  logic signed [47:0] biased [4];
  logic signed [47:0] shifted [4];
  ref_t               ref_nxt [4];
  ref_t               ref4_r [4];
  logic               mot4_r;

  always_comb begin
    sx2w = sx2_r;
    sy2w = sy2_r;
    sx2w = sx2w <<< 1;
    sy2w = sy2w <<< 1;
    tot_nxt[WHEEL_FL] =  sx2w + sy2w - 48'(wg2_r[WHEEL_FL]);
    tot_nxt[WHEEL_FR] =  sx2w - sy2w - 48'(wg2_r[WHEEL_FR]);
    tot_nxt[WHEEL_BL] = -sx2w + sy2w - 48'(wg2_r[WHEEL_BL]);
    tot_nxt[WHEEL_BR] = -sx2w - sy2w - 48'(wg2_r[WHEEL_BR]);
  end

  for (genvar w = 0; w < 4; w++) begin : g_wheel
    // round half away from zero, then clamp to the reference range
    always_comb begin
      biased[w]  = tot3_r[w] + ((tot3_r[w] < 0) ? 48'sd32767 : 48'sd32768);
      shifted[w] = biased[w] >>> 16;
      if (shifted[w] > 48'(REF_MAX))      ref_nxt[w] = ref_t'(REF_MAX);
      else if (shifted[w] < 48'(REF_MIN)) ref_nxt[w] = ref_t'(REF_MIN);
      else                                ref_nxt[w] = shifted[w][23:0];
    end

    always_ff @(posedge clk) begin
      if (en[1]) wg1_r[w]  <= wz * gain[w];
      if (en[2]) wg2_r[w]  <= wg1_r[w];
      if (en[3]) tot3_r[w] <= tot_nxt[w];
      if (en[4]) ref4_r[w] <= ref_nxt[w];
    end

    assign wheel_ref[w] = ref4_r[w];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      xc1_r  <= vx * cos_val;
      ys1_r  <= vy * sin_val;
      yc1_r  <= vy * cos_val;
      xs1_r  <= vx * sin_val;
      mot1_r <= motors;
    end
    if (en[2]) begin
      sx2_r  <= 34'(xc1_r) + 34'(ys1_r);
      sy2_r  <= 34'(yc1_r) - 34'(xs1_r);
      mot2_r <= mot1_r;
    end
    if (en[3]) mot3_r <= mot2_r;
    if (en[4]) mot4_r <= mot3_r;
  end

  assign motors_enabled = mot4_r;

endmodule
